>>> src/gsf_pkg.sv
package gsf_pkg;

	localparam int DEF_IN_SIZE    = 16;
	localparam int DEF_UNITS      = 16;
	localparam int DEF_BATCH_ROWS = 4;

	localparam int VAL_W = 16;
	localparam int ACC_W = 40;
	localparam int DOT_W = 40;

	localparam logic [2:0] CMD_LD_IW = 3'd0;
	localparam logic [2:0] CMD_LD_RW = 3'd1;
	localparam logic [2:0] CMD_LD_B  = 3'd2;
	localparam logic [2:0] CMD_LD_H  = 3'd3;
	localparam logic [2:0] CMD_X     = 3'd4;

	localparam logic [63:0] Q30      = 64'd1 << 30;
	localparam logic [63:0] EXP_STEP = 64'd1008687096;

	typedef logic [128:0][12:0] tab_t;

	// shift-subtract quotient, evaluated at elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] qt;
		logic [63:0] rm;
		qt = '0;
		rm = '0;
		for (int i = 63; i >= 0; i--) begin
			rm = {rm[62:0], n[i]};
			if (rm >= d) begin
				rm = rm - d;
				qt[i] = 1'b1;
			end
		end
		return qt;
	endfunction

	function automatic tab_t build_tab(input logic is_tanh);
		logic [63:0] e [0:256];
		tab_t t;
		logic [63:0] d;
		logic [63:0] nm;
		logic [63:0] qt;
		e[0] = Q30;
		for (int k = 1; k <= 256; k++)
			e[k] = (e[k-1] * EXP_STEP + (Q30 >> 1)) >> 30;
		for (int k = 0; k <= 128; k++) begin
			if (is_tanh) begin
				d  = Q30 + e[2*k];
				nm = ((Q30 - e[2*k]) << 12) + (d >> 1);
			end else begin
				d  = Q30 + e[k];
				nm = (64'd1 << 42) + (d >> 1);
			end
			qt = udiv64(nm, d);
			t[k] = qt[12:0];
		end
		return t;
	endfunction

	localparam tab_t SIG_TAB  = build_tab(1'b0);
	localparam tab_t TANH_TAB = build_tab(1'b1);

	// Q40.24 to Q4.12: round half up, then saturate
	function automatic logic signed [15:0] to_q12(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = (v + 64'sd2048) >>> 12;
		if (t > 64'sd32767)
			return 16'sh7fff;
		if (t < -64'sd32768)
			return 16'sh8000;
		return t[15:0];
	endfunction

endpackage

>>> src/gsf_if.sv
interface gsf_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [3:0]  row;
	logic [5:0]  col;
	logic [1:0]  batch;
	logic signed [15:0] value;
	logic        last_element;

	modport source(output valid, cmd, row, col, batch, value, last_element, input ready);
	modport sink(input valid, cmd, row, col, batch, value, last_element, output ready);
endinterface

interface gsf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_batch;
	logic [3:0]  unit;
	logic signed [15:0] hidden_out;
	logic        last_unit;

	modport source(output valid, out_batch, unit, hidden_out, last_unit, input ready);
	modport sink(input valid, out_batch, unit, hidden_out, last_unit, output ready);
endinterface

>>> src/gsf_ram.sv
module gsf_ram #(
	parameter int W = 16,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [0:D-1];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> src/gsf_cell.sv
module gsf_cell #(
	parameter int W = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                shift,
	input  logic signed [W-1:0] d,
	output logic signed [W-1:0] q
);
	// hold one gate sum; take the neighbor's on shift, drop it on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (clr) begin
			q <= '0;
		end else if (shift) begin
			q <= d;
		end
	end
endmodule

>>> src/gru_sequence_forward_top.sv
// GRU forward step, Q4.12. Load beats write their store and leave the block idle.
// An x element beat does one input-weight read per gate through
// one shared 16x16 multiplier, sums rotated through a row of gate cells.
// A beat marked last then runs, per unit, a recurrent dot product, sum and lookup per gate,
// a blend and an output that waits for ready, and then clears the gate sums.
// Reset clears hidden state (valid bits) and gate sums; weights stay undefined.
module gru_sequence_forward_top #(
	parameter int IN_SIZE    = gsf_pkg::DEF_IN_SIZE,
	parameter int UNITS      = gsf_pkg::DEF_UNITS,
	parameter int BATCH_ROWS = gsf_pkg::DEF_BATCH_ROWS
) (
	input logic     clk,
	input logic     arst_n,
	gsf_in_if.sink  req,
	gsf_out_if.source rsp
);
	import gsf_pkg::*;

	localparam int NGATE = 3 * UNITS;
	localparam int IA_D  = IN_SIZE * NGATE;
	localparam int RA_D  = UNITS * NGATE;
	localparam int HD    = 2 * BATCH_ROWS * UNITS;
	localparam int IA_W  = $clog2(IA_D);
	localparam int RA_W  = $clog2(RA_D);
	localparam int BA_W  = $clog2(NGATE);
	localparam int HA_W  = $clog2(HD);
	localparam int CW    = $clog2(NGATE + 1);
	localparam int JW    = $clog2(UNITS + 1);
	localparam int BW    = (BATCH_ROWS > 1) ? $clog2(BATCH_ROWS) : 1;
	localparam int RC_W  = DOT_W + 14;
	localparam int ZW    = ACC_W + 4;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACC  = 4'd1;
	localparam logic [3:0] S_MAC  = 4'd2;
	localparam logic [3:0] S_RC   = 4'd3;
	localparam logic [3:0] S_ZSUM = 4'd4;
	localparam logic [3:0] S_ACT1 = 4'd5;
	localparam logic [3:0] S_ACT2 = 4'd6;
	localparam logic [3:0] S_BL1  = 4'd7;
	localparam logic [3:0] S_BL2  = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;
	localparam logic [3:0] S_CLR  = 4'd10;

	logic [3:0]    st_q;
	logic [3:0]    row_q;
	logic [1:0]    batch_q;
	logic          last_q;
	logic signed [15:0] x_q;
	logic [CW-1:0] ic_q;
	logic [CW-1:0] dc_q;
	logic [JW-1:0] j_q;
	logic [1:0]    g_q;
	logic          v_s1;
	logic          v_s2;
	logic [CW-1:0] k_s1;
	logic signed [31:0] prod_s2;
	logic signed [DOT_W-1:0] dot_q;
	logic signed [RC_W-1:0]  rc_q;
	logic signed [15:0] z_q;
	logic          neg_q;
	logic [12:0]   t0_q;
	logic [12:0]   t1_q;
	logic [7:0]    f_q;
	logic [12:0]   r_q;
	logic [12:0]   u_q;
	logic signed [13:0] c_q;
	logic signed [15:0] hj_q;
	logic signed [27:0] p1_q;
	logic signed [29:0] p2_q;
	logic [BATCH_ROWS-1:0] sel_q;
	logic [HD-1:0] hval_q;
	logic          hv_s1;
	logic          ov_q;
	logic [1:0]    ob_q;
	logic [3:0]    ou_q;
	logic signed [15:0] oh_q;
	logic          ol_q;

	logic acc_in;
	assign req.ready = (st_q == S_IDLE);
	assign acc_in    = req.valid && req.ready;

	// ---------------- weight, bias and hidden stores ----------------
	logic row_in_ok, rrow_ok, col_ok, bat_ok, bq_ok;
	assign row_in_ok = int'(req.row) < IN_SIZE;
	assign rrow_ok   = int'(req.row) < UNITS;
	assign col_ok    = int'(req.col) < NGATE;
	assign bat_ok    = int'(req.batch) < BATCH_ROWS;
	assign bq_ok     = int'(batch_q) < BATCH_ROWS;

	logic [BW-1:0] bin;
	logic [BW-1:0] bqi;
	assign bin = BW'(req.batch);
	assign bqi = BW'(batch_q);

	logic            iw_we;
	logic [IA_W-1:0] iw_wa, iw_ra;
	logic [15:0]     iw_rd;
	assign iw_we = acc_in && req.cmd == CMD_LD_IW && row_in_ok && col_ok;
	assign iw_wa = IA_W'(int'(req.row) * NGATE + int'(req.col));
	assign iw_ra = IA_W'(int'(row_q) * NGATE + int'(ic_q));

	gsf_ram #(.W(VAL_W), .D(IA_D)) u_iw (
		.clk(clk), .we(iw_we), .waddr(iw_wa), .wdata(req.value),
		.raddr(iw_ra), .rdata(iw_rd)
	);

	logic            rw_we;
	logic [RA_W-1:0] rw_wa, rw_ra;
	logic [15:0]     rw_rd;
	assign rw_we = acc_in && req.cmd == CMD_LD_RW && rrow_ok && col_ok;
	assign rw_wa = RA_W'(int'(req.row) * NGATE + int'(req.col));
	assign rw_ra = RA_W'(int'(ic_q) * NGATE + int'(g_q) * UNITS + int'(j_q));

	gsf_ram #(.W(VAL_W), .D(RA_D)) u_rw (
		.clk(clk), .we(rw_we), .waddr(rw_wa), .wdata(req.value),
		.raddr(rw_ra), .rdata(rw_rd)
	);

	logic            b_we;
	logic [BA_W-1:0] b_wa, b_ra;
	logic [15:0]     b_rd;
	assign b_we = acc_in && req.cmd == CMD_LD_B && col_ok;
	assign b_wa = BA_W'(req.col);
	assign b_ra = BA_W'(int'(g_q) * UNITS + int'(j_q));

	gsf_ram #(.W(VAL_W), .D(NGATE)) u_b (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(req.value),
		.raddr(b_ra), .rdata(b_rd)
	);

	// Hidden store is two banks per batch row: read the live bank, write the
	// new vector into the other one, flip the bank at the end of the step.
	logic            h_ld, h_we;
	logic [HA_W-1:0] h_wa, h_ra;
	logic [15:0]     h_wd, h_rd;
	logic signed [15:0] newh;
	logic signed [15:0] hid_data;
	assign h_ld = acc_in && req.cmd == CMD_LD_H && rrow_ok && bat_ok;
	assign h_we = h_ld || (st_q == S_BL2);
	assign h_wa = h_ld
		? HA_W'(int'(sel_q[bin]) * BATCH_ROWS * UNITS + int'(req.batch) * UNITS + int'(req.row))
		: HA_W'(int'(!sel_q[bqi]) * BATCH_ROWS * UNITS + int'(batch_q) * UNITS + int'(j_q));
	assign h_wd = h_ld ? req.value : newh;
	assign h_ra = HA_W'(int'(sel_q[bqi]) * BATCH_ROWS * UNITS + int'(batch_q) * UNITS
		+ int'(ic_q));

	gsf_ram #(.W(VAL_W), .D(HD)) u_h (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
		.raddr(h_ra), .rdata(h_rd)
	);

	// never-written hidden entries read as zero
	assign hid_data = hv_s1 ? $signed(h_rd) : 16'sd0;

	// ---------------- shared multiplier ----------------
	logic signed [15:0] mul_a, mul_b;
	assign mul_a = (st_q == S_ACC) ? x_q : hid_data;
	assign mul_b = (st_q == S_ACC) ? $signed(iw_rd) : $signed(rw_rd);

	// ---------------- gate cell row ----------------
	// Accumulate: the head cell plus the product enters at the tail, so cell 0
	// holds gate g on the g-th product. Finish: rotate once per unit so cells
	// 0, UNITS and 2*UNITS hold that unit's reset, update and cell sums.
	logic signed [ACC_W-1:0] acc_c [0:NGATE-1];
	logic signed [ACC_W-1:0] tail_d;
	logic signed [ACC_W:0]   hsum;
	logic cell_shift, cell_clr;

	assign hsum = (ACC_W+1)'(acc_c[0]) + (ACC_W+1)'(prod_s2);
	always_comb begin
		if (st_q != S_ACC)
			tail_d = acc_c[0];
		else if (hsum[ACC_W] != hsum[ACC_W-1])
			tail_d = hsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			tail_d = hsum[ACC_W-1:0];
	end
	assign cell_shift = (st_q == S_ACC && v_s2) || (st_q == S_EMIT && rsp.ready);
	assign cell_clr   = (st_q == S_CLR);

	for (genvar i = 0; i < NGATE; i++) begin : g_cell
		gsf_cell #(.W(ACC_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .clr(cell_clr), .shift(cell_shift),
			.d((i == NGATE - 1) ? tail_d : acc_c[(i + 1) % NGATE]),
			.q(acc_c[i])
		);
	end

	// ---------------- gate pre-activation ----------------
	logic signed [ACC_W-1:0] tap;
	logic signed [RC_W-1:0]  rcr;
	logic signed [ZW-1:0]    zsum;
	always_comb begin
		case (g_q)
			2'd0:    tap = acc_c[0];
			2'd1:    tap = acc_c[UNITS];
			default: tap = acc_c[2*UNITS];
		endcase
	end
	assign rcr  = (rc_q + RC_W'(2048)) >>> 12;
	assign zsum = ZW'(tap) + ((g_q == 2'd2) ? ZW'(rcr) : ZW'(dot_q))
		+ (ZW'($signed(b_rd)) <<< 12);

	// ---------------- activation lookup ----------------
	logic [15:0] za;
	logic [7:0]  zi;
	logic [7:0]  zi1;
	tab_t        tab;
	logic [20:0] interp;
	logic [12:0] lk;
	assign za     = z_q[15] ? 16'(-z_q) : 16'(z_q);
	assign zi     = za[15:8];
	assign zi1    = zi + 8'd1;
	assign tab    = (g_q == 2'd2) ? TANH_TAB : SIG_TAB;
	assign interp = (21'(t1_q - t0_q) * 21'(f_q) + 21'd128) >> 8;
	assign lk     = t0_q + interp[12:0];

	assign newh = to_q12(64'(p1_q) + 64'(p2_q));

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			ic_q   <= '0;
			dc_q   <= '0;
			j_q    <= '0;
			g_q    <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			sel_q  <= '0;
			hval_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			if (h_we)
				hval_q[h_wa] <= 1'b1;
			case (st_q)
				S_IDLE: begin
					ic_q <= '0;
					dc_q <= '0;
					j_q  <= '0;
					g_q  <= '0;
					if (acc_in && req.cmd == CMD_X) begin
						if (row_in_ok)
							st_q <= S_ACC;
						else if (req.last_element)
							st_q <= bat_ok ? S_MAC : S_CLR;
					end
				end
				S_ACC: begin
					if (int'(ic_q) < NGATE) begin
						ic_q <= ic_q + 1'b1;
						v_s1 <= 1'b1;
					end
					if (v_s2) begin
						dc_q <= dc_q + 1'b1;
						if (int'(dc_q) == NGATE - 1) begin
							ic_q <= '0;
							dc_q <= '0;
							if (!last_q)
								st_q <= S_IDLE;
							else
								st_q <= bq_ok ? S_MAC : S_CLR;
						end
					end
				end
				S_MAC: begin
					if (int'(ic_q) < UNITS) begin
						ic_q <= ic_q + 1'b1;
						v_s1 <= 1'b1;
					end
					if (v_s2) begin
						dc_q <= dc_q + 1'b1;
						if (int'(dc_q) == UNITS - 1) begin
							ic_q <= '0;
							dc_q <= '0;
							st_q <= (g_q == 2'd2) ? S_RC : S_ZSUM;
						end
					end
				end
				S_RC:   st_q <= S_ZSUM;
				S_ZSUM: st_q <= S_ACT1;
				S_ACT1: st_q <= S_ACT2;
				S_ACT2: begin
					if (g_q == 2'd2) begin
						st_q <= S_BL1;
					end else begin
						g_q  <= g_q + 2'd1;
						st_q <= S_MAC;
					end
				end
				S_BL1: st_q <= S_BL2;
				S_BL2: begin
					ov_q <= 1'b1;
					st_q <= S_EMIT;
				end
				S_EMIT: begin
					if (rsp.ready) begin
						ov_q <= 1'b0;
						g_q  <= '0;
						if (int'(j_q) == UNITS - 1) begin
							sel_q[bqi] <= !sel_q[bqi];
							st_q <= S_CLR;
						end else begin
							j_q  <= j_q + 1'b1;
							st_q <= S_MAC;
						end
					end
				end
				S_CLR:   st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		k_s1  <= ic_q;
		hv_s1 <= hval_q[h_ra];
		if (acc_in) begin
			row_q   <= req.row;
			batch_q <= req.batch;
			last_q  <= req.last_element;
			x_q     <= req.value;
		end
		if (v_s1)
			prod_s2 <= 32'(mul_a) * 32'(mul_b);
		if (st_q == S_MAC && ic_q == '0 && dc_q == '0 && !v_s1 && !v_s2)
			dot_q <= '0;
		else if (st_q == S_MAC && v_s2)
			dot_q <= dot_q + DOT_W'(prod_s2);
		// keep this unit's old hidden value for the blend
		if (st_q == S_MAC && v_s1 && g_q == 2'd0 && int'(k_s1) == int'(j_q))
			hj_q <= hid_data;
		if (st_q == S_RC)
			rc_q <= RC_W'($signed({1'b0, r_q})) * RC_W'(dot_q);
		if (st_q == S_ZSUM)
			z_q <= to_q12(64'(zsum));
		if (st_q == S_ACT1) begin
			neg_q <= z_q[15];
			t0_q  <= za[15] ? tab[128] : tab[zi];
			t1_q  <= za[15] ? tab[128] : tab[zi1];
			f_q   <= za[15] ? 8'd0 : za[7:0];
		end
		if (st_q == S_ACT2) begin
			case (g_q)
				2'd0:    r_q <= neg_q ? 13'd4096 - lk : lk;
				2'd1:    u_q <= neg_q ? 13'd4096 - lk : lk;
				default: c_q <= neg_q ? -$signed({1'b0, lk}) : $signed({1'b0, lk});
			endcase
		end
		if (st_q == S_BL1) begin
			p1_q <= 28'($signed({1'b0, 13'd4096 - u_q})) * 28'(c_q);
			p2_q <= 30'($signed({1'b0, u_q})) * 30'(hj_q);
		end
		if (st_q == S_BL2) begin
			ob_q <= batch_q;
			ou_q <= 4'(j_q);
			oh_q <= newh;
			ol_q <= (int'(j_q) == UNITS - 1);
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.out_batch  = ob_q;
	assign rsp.unit       = ou_q;
	assign rsp.hidden_out = oh_q;
	assign rsp.last_unit  = ol_q;

	// ---------------- checks ----------------
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> st_q == S_EMIT)
		else $error("result shown outside emit");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid)
		else $error("input taken while a result waits");

	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ACC && v_s2) |-> int'(dc_q) < NGATE)
		else $error("gate rotation overran");

	a_emit_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT && rsp.ready && !rsp.last_unit) |=> st_q == S_MAC)
		else $error("unit sequence broken");
endmodule
